// File: rtl/core/csc_pkg.sv
`default_nettype none

package csc_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int ANGLE_WIDTH   = 24;
   localparam int CORDIC_STAGES = 24;

   localparam int PRESCALE = 24;
   localparam int DW       = COORD_WIDTH + PRESCALE + 4;
   localparam int ACW      = 34;
   localparam int ANG_SH   = 32 - ANGLE_WIDTH;
   localparam int SQW      = 2 * COORD_WIDTH + 1;
   localparam int KPW      = COORD_WIDTH + 32;
   localparam int PW       = COORD_WIDTH + 33;
   localparam int RSW      = PW - 30;
   localparam int QW       = RSW + 32;
   localparam int OW       = COORD_WIDTH + 1;
   localparam int TAB_LEN  = 32;

   localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned r, b, w;
      w = v;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > w) b = b >> 2;
      while (b != 64'd0) begin
         if (w >= r + b) begin
            w = w - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned gain_q30();
      longint unsigned p;
      p = 64'd1 << 60;
      for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) p = p + (p >> (2 * i));
      return isqrt64(p);
   endfunction

   localparam longint unsigned GAIN = gain_q30();
   localparam longint unsigned X0_U = ((64'd1 << 60) + GAIN / 2) / GAIN;
   localparam logic signed [31:0]     GAIN_S  = 32'(GAIN);
   localparam logic signed [DW-1:0]   X0      = DW'(X0_U);
   localparam logic signed [ACW-1:0]  HALF_PI = ACW'(64'd1 << 30);
   localparam logic signed [ACW-1:0]  PI      = ACW'(64'd1 << 31);
   localparam logic signed [ACW-1:0]  PHI_MAX = ACW'(64'd1 << (ANGLE_WIDTH - 1));

   typedef struct packed {
      logic signed [DW-1:0]  x;
      logic signed [DW-1:0]  y;
      logic signed [ACW-1:0] a;
   } lane_type;

   typedef struct packed {
      logic                     kind;
      logic                     degen;
      logic                     xyzero;
      lane_type                 la;
      lane_type                 lb;
      logic [2*COORD_WIDTH-1:0] sq1;
      logic [2*COORD_WIDTH-1:0] sq2;
      logic [2*COORD_WIDTH-1:0] sq3;
      logic [SQW-1:0]           sq_v;
      logic [SQW-1:0]           sq_r;
      logic signed [DW-1:0]     kz;
      logic [COORD_WIDTH-1:0]   rho;
      logic signed [PW-1:0]     prs;
      logic signed [PW-1:0]     pz;
      logic signed [QW-1:0]     px;
      logic signed [QW-1:0]     py;
      logic signed [OW-1:0]     ox;
      logic signed [OW-1:0]     oy;
      logic signed [OW-1:0]     oz;
   } item_type;

   function automatic lane_type cordic_iter(input lane_type l, input logic vec, input int i);
      logic signed [DW-1:0]  x, y, dx, dy;
      logic signed [ACW-1:0] a, t;
      logic                  up;
      lane_type              r;
      x  = l.x;
      y  = l.y;
      a  = l.a;
      dx = y >>> i;
      dy = x >>> i;
      t  = ACW'(ATAN_TAB[i[4:0]]);
      up = vec ? ~y[DW-1] : a[ACW-1];
      if (up) begin
         r.x = x + dx;
         r.y = y - dy;
         r.a = a + t;
      end else begin
         r.x = x - dx;
         r.y = y + dy;
         r.a = a - t;
      end
      return r;
   endfunction

   function automatic lane_type vec_fold(input logic signed [DW-1:0] x,
                                         input logic signed [DW-1:0] y);
      lane_type r;
      if (x < 0) begin
         if (y >= 0) begin
            r.x = y;
            r.y = -x;
            r.a = HALF_PI;
         end else begin
            r.x = -y;
            r.y = x;
            r.a = -HALF_PI;
         end
      end else begin
         r.x = x;
         r.y = y;
         r.a = '0;
      end
      return r;
   endfunction

   function automatic lane_type rot_init(input logic [ANGLE_WIDTH-1:0] v);
      logic [31:0]           u;
      logic signed [ACW-1:0] a;
      lane_type              r;
      u   = 32'(v) << ANG_SH;
      a   = ACW'(signed'(u));
      r.y = '0;
      if (a > HALF_PI) begin
         r.a = a - PI;
         r.x = -X0;
      end else if (a < -HALF_PI) begin
         r.a = a + PI;
         r.x = -X0;
      end else begin
         r.a = a;
         r.x = X0;
      end
      return r;
   endfunction

   function automatic item_type sqrt_step(input item_type s, input int j);
      logic [SQW-1:0] b, t;
      item_type       r;
      r = s;
      b = SQW'(1) << (2 * (COORD_WIDTH - 1 - j));
      t = s.sq_r + b;
      if (s.sq_v >= t) begin
         r.sq_v = s.sq_v - t;
         r.sq_r = (s.sq_r >> 1) + b;
      end else begin
         r.sq_r = s.sq_r >> 1;
      end
      return r;
   endfunction

   function automatic longint rnd30(input longint v);
      longint t;
      t = v + (64'sd1 <<< 29);
      return t >>> 30;
   endfunction

   function automatic logic signed [OW-1:0] sat_c(input longint v);
      longint hi, lo;
      hi = (64'sd1 <<< COORD_WIDTH) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) return OW'(hi);
      if (v < lo) return OW'(lo);
      return OW'(v);
   endfunction

   function automatic logic signed [ACW-1:0] angle_round(input logic signed [ACW-1:0] a);
      logic signed [ACW-1:0] t;
      if (ANG_SH == 0) return a;
      t = a + (ACW'(1) <<< (ANG_SH - 1));
      return t >>> ANG_SH;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/csc_front.sv
`default_nettype none

module csc_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic                                     kind,
   input  logic signed [csc_pkg::COORD_WIDTH-1:0]   in_x,
   input  logic signed [csc_pkg::COORD_WIDTH-1:0]   in_y,
   input  logic signed [csc_pkg::COORD_WIDTH-1:0]   in_z,
   input  logic        [csc_pkg::COORD_WIDTH-1:0]   in_rho,
   input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]   in_theta,
   input  logic        [csc_pkg::ANGLE_WIDTH-1:0]   in_phi,
   output logic                                     out_valid,
   output csc_pkg::item_type                        out_item
);
   import csc_pkg::*;

   item_type                     p1_in, p1_ff, p2_in, p2_ff;
   logic                         v1_ff, v2_ff;
   logic signed [COORD_WIDTH:0]  xs, ys, zs;
   logic [COORD_WIDTH-1:0]       xa, ya, za;
   logic signed [KPW-1:0]        zk;

   always_comb begin
      xs = (COORD_WIDTH+1)'(in_x);
      ys = (COORD_WIDTH+1)'(in_y);
      zs = (COORD_WIDTH+1)'(in_z);
      xa = COORD_WIDTH'(xs < 0 ? -xs : xs);
      ya = COORD_WIDTH'(ys < 0 ? -ys : ys);
      za = COORD_WIDTH'(zs < 0 ? -zs : zs);
      zk = KPW'(in_z) * KPW'(GAIN_S);
      p1_in        = '0;
      p1_in.kind   = kind;
      p1_in.degen  = (in_x == '0) && (in_y == '0) && (in_z == '0);
      p1_in.xyzero = (in_x == '0) && (in_y == '0);
      if (!kind) begin
         p1_in.la = vec_fold(DW'(in_x) <<< PRESCALE, DW'(in_y) <<< PRESCALE);
      end else begin
         p1_in.la = rot_init(in_theta);
      end
      p1_in.lb  = rot_init(in_phi);
      p1_in.sq1 = (2*COORD_WIDTH)'(xa) * (2*COORD_WIDTH)'(xa);
      p1_in.sq2 = (2*COORD_WIDTH)'(ya) * (2*COORD_WIDTH)'(ya);
      p1_in.sq3 = (2*COORD_WIDTH)'(za) * (2*COORD_WIDTH)'(za);
      p1_in.kz  = DW'(zk >>> (30 - PRESCALE));
      p1_in.rho = in_rho;
   end

   always_comb begin
      p2_in      = p1_ff;
      p2_in.sq_v = SQW'(p1_ff.sq1) + SQW'(p1_ff.sq2) + SQW'(p1_ff.sq3);
      p2_in.sq_r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = p2_ff;

endmodule

`default_nettype wire

// File: rtl/core/csc_cordic_a.sv
`default_nettype none

module csc_cordic_a (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  csc_pkg::item_type in_item,
   output logic              out_valid,
   output csc_pkg::item_type out_item
);
   import csc_pkg::*;

   item_type st_ff  [CORDIC_STAGES];
   logic     vld_ff [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      item_type src, nxt_in;
      logic     src_v;

      if (i == 0) begin : g_first
         assign src   = in_item;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = st_ff[i-1];
         assign src_v = vld_ff[i-1];
      end

      // azimuth vectoring or rotations, and one root digit
      always_comb begin
         nxt_in    = src;
         nxt_in.la = cordic_iter(src.la, ~src.kind, i);
         nxt_in.lb = cordic_iter(src.lb, 1'b0, i);
         if (i < COORD_WIDTH) nxt_in = sqrt_step(nxt_in, i);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= nxt_in;
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];
   assign out_item  = st_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/csc_cordic_b.sv
`default_nettype none

module csc_cordic_b (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  csc_pkg::item_type in_item,
   output logic              out_valid,
   output csc_pkg::item_type out_item
);
   import csc_pkg::*;

   item_type st_ff  [CORDIC_STAGES];
   logic     vld_ff [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      item_type              src, nxt_in;
      logic                  src_v;
      lane_type              lane;
      logic signed [RSW-1:0] rs;

      if (i == 0) begin : g_first
         assign src   = in_item;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = st_ff[i-1];
         assign src_v = vld_ff[i-1];
      end

      // polar vectoring, and the products of the spherical to cartesian path
      always_comb begin
         nxt_in = src;
         rs     = '0;
         if (i == 0) begin
            lane = vec_fold(src.kz, src.xyzero ? '0 : src.la.x);
         end else begin
            lane = src.lb;
         end
         nxt_in.lb = cordic_iter(lane, 1'b1, i);
         if (i == 0) begin
            nxt_in.prs = PW'(signed'({1'b0, src.rho})) * PW'(signed'(src.lb.y[31:0]));
            nxt_in.pz  = PW'(signed'({1'b0, src.rho})) * PW'(signed'(src.lb.x[31:0]));
         end
         if (i == 1) begin
            rs        = RSW'(rnd30(64'(src.prs)));
            nxt_in.px = QW'(rs) * QW'(signed'(src.la.x[31:0]));
            nxt_in.py = QW'(rs) * QW'(signed'(src.la.y[31:0]));
            nxt_in.oz = sat_c(rnd30(64'(src.pz)));
         end
         if (i == 2) begin
            nxt_in.ox = sat_c(rnd30(64'(src.px)));
            nxt_in.oy = sat_c(rnd30(64'(src.py)));
         end
         if (CORDIC_STAGES + i < COORD_WIDTH) nxt_in = sqrt_step(nxt_in, CORDIC_STAGES + i);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i] <= nxt_in;
         end
      end
   end

   assign out_valid = vld_ff[CORDIC_STAGES-1];
   assign out_item  = st_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/cartesian_spherical_converter.sv
`default_nettype none

// Converts one point per request between Cartesian and spherical form (tuser 0: x, y, z in,
// rho, theta, phi out; tuser 1: the reverse). Angles are binary angles, 2^23 = pi. The block
// is a pipeline: two input stages, one chain of CORDIC stages for the azimuth (or both
// rotations) and the root digits, a second chain for the polar angle (or the scaling
// products), and the output register. One request is taken every cycle; when the output is
// not taken the whole pipeline holds.

module cartesian_spherical_converter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // in_x, in_y, in_z, in_rho, in_theta, in_phi
   input  logic [143:0] req_tdata,
   // kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_rho, out_theta, out_phi, out_x, out_y, out_z, zero pad
   output logic [151:0] rsp_tdata,
   // degenerate
   output logic         rsp_tuser
);
   import csc_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int AW     = ANGLE_WIDTH;
   localparam int RSP_W  = 152;

   logic                   en;
   logic                   f_valid, a_valid, b_valid;
   item_type               f_item, a_item, b_item;
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic [SQW-1:0]         rr;
   logic [CW-1:0]          o_rho;
   logic signed [ACW-1:0]  tr, pr;
   logic [AW-1:0]          o_theta, o_phi;
   logic signed [OW-1:0]   o_x, o_y, o_z;

   assign en         = ~rsp_valid_ff | rsp_tready;
   assign req_tready = en;

   csc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .kind     (req_tuser),
      .in_x     (signed'(req_tdata[CW-1:0])),
      .in_y     (signed'(req_tdata[2*CW-1:CW])),
      .in_z     (signed'(req_tdata[3*CW-1:2*CW])),
      .in_rho   (req_tdata[4*CW-1:3*CW]),
      .in_theta (signed'(req_tdata[4*CW+AW-1:4*CW])),
      .in_phi   (req_tdata[4*CW+2*AW-1:4*CW+AW]),
      .out_valid(f_valid),
      .out_item (f_item)
   );

   csc_cordic_a u_cordic_a (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (f_valid),
      .in_item  (f_item),
      .out_valid(a_valid),
      .out_item (a_item)
   );

   csc_cordic_b u_cordic_b (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (a_valid),
      .in_item  (a_item),
      .out_valid(b_valid),
      .out_item (b_item)
   );

   always_comb begin
      rr = b_item.sq_r + SQW'(b_item.sq_v > b_item.sq_r);
      if (rr > SQW'({CW{1'b1}})) begin
         o_rho = {CW{1'b1}};
      end else begin
         o_rho = CW'(rr);
      end
      tr = angle_round(b_item.la.a);
      pr = angle_round(b_item.lb.a);
      if (b_item.degen || b_item.xyzero) begin
         o_theta = '0;
      end else begin
         o_theta = tr[AW-1:0];
      end
      if (b_item.degen || pr < 0) begin
         o_phi = '0;
      end else if (pr > PHI_MAX) begin
         o_phi = PHI_MAX[AW-1:0];
      end else begin
         o_phi = pr[AW-1:0];
      end
      o_x = b_item.ox;
      o_y = b_item.oy;
      o_z = b_item.oz;
      if (b_item.kind) begin
         o_rho   = '0;
         o_theta = '0;
         o_phi   = '0;
         rsp_user_in = 1'b0;
      end else begin
         o_x = '0;
         o_y = '0;
         o_z = '0;
         rsp_user_in = b_item.degen;
      end
      rsp_data_in = RSP_W'({o_z, o_y, o_x, o_phi, o_theta, o_rho});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// File: dv/cartesian_spherical_checker.sv
module cartesian_spherical_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending
);
   import csc_pkg::*;

   localparam longint HALF_PI_A = 64'sd1 <<< 30;
   localparam longint PI_A      = 64'sd1 <<< 31;

   typedef struct packed {
      logic [23:0] rho;
      logic [23:0] theta;
      logic [23:0] phi;
      logic [24:0] x;
      logic [24:0] y;
      logic [24:0] z;
      logic        degen;
   } point_type;

   point_type points_due[$];
   longint    arctan_q31[32];
   longint    gain_k;
   longint    recip_k;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root_of(longint unsigned v, output longint unsigned rem);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      rem = v;
      return r;
   endfunction

   function automatic longint angle_of(longint x, longint y, output longint mag);
      longint acc, t, dx, dy;
      acc = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; acc = HALF_PI_A;
         end else begin
            x = -y; y = t; acc = -HALF_PI_A;
         end
      end
      for (int i = 0; i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; acc += arctan_q31[i];
         end else begin
            x -= dx; y += dy; acc -= arctan_q31[i];
         end
      end
      mag = x;
      return acc;
   endfunction

   function automatic void cos_sin(longint a, output longint c, output longint s);
      longint x, y, dx, dy;
      x = recip_k;
      y = 0;
      if (a > HALF_PI_A) begin
         a -= PI_A; x = -recip_k;
      end else if (a < -HALF_PI_A) begin
         a += PI_A; x = -recip_k;
      end
      for (int i = 0; i < 24; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (a >= 0) begin
            x -= dx; y += dy; a -= arctan_q31[i];
         end else begin
            x += dx; y -= dy; a += arctan_q31[i];
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint to_out_angle(longint a);
      return floor_shift(a + (64'sd1 <<< 7), 8);
   endfunction

   function automatic longint to_q31(logic [23:0] v);
      logic [31:0] u;
      u = {v, 8'd0};
      return longint'(signed'(u));
   endfunction

   function automatic longint half_up30(longint v);
      return floor_shift(v + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic [24:0] clip25(longint v);
      if (v > 64'sd16777215) return 25'h0FFFFFF;
      if (v < -64'sd16777216) return 25'h1000000;
      return v[24:0];
   endfunction

   function automatic point_type convert_point(logic kind, logic [143:0] d);
      point_type p;
      longint x, y, z, theta, phi, mxy, m2, kz, rho, ct, st, cp, sp, rs;
      longint unsigned rem, r;
      p = '0;
      if (!kind) begin
         x = longint'(signed'(d[23:0]));
         y = longint'(signed'(d[47:24]));
         z = longint'(signed'(d[71:48]));
         r = root_of(longint'(x * x + y * y + z * z), rem);
         if (rem > r) r++;
         if (r > 64'd16777215) r = 64'd16777215;
         p.rho = r[23:0];
         if (x == 0 && y == 0 && z == 0) begin
            p.degen = 1'b1;
         end else begin
            theta = angle_of(x <<< 24, y <<< 24, mxy);
            if (x == 0 && y == 0) begin
               theta = 0; mxy = 0;
            end
            kz = floor_shift(z * gain_k, 6);
            phi = to_out_angle(angle_of(kz, mxy, m2));
            if (phi < 0) phi = 0;
            if (phi > 64'sd8388608) phi = 64'sd8388608;
            theta = to_out_angle(theta);
            p.theta = theta[23:0];
            p.phi = phi[23:0];
         end
      end else begin
         rho = longint'(d[95:72]);
         cos_sin(to_q31(d[119:96]), ct, st);
         cos_sin(to_q31(d[143:120]), cp, sp);
         rs = half_up30(rho * sp);
         p.x = clip25(half_up30(rs * ct));
         p.y = clip25(half_up30(rs * st));
         p.z = clip25(half_up30(rho * cp));
      end
      return p;
   endfunction

   initial begin
      longint unsigned pk, rem;
      for (int i = 0; i < 32; i++) arctan_q31[i] = longint'(ATAN_TAB[i]);
      pk = 64'd1 << 60;
      for (int i = 0; i < 24; i++) pk = pk + (pk >> (2 * i));
      gain_k = longint'(root_of(pk, rem));
      recip_k = longint'(((64'd1 << 60) + gain_k / 2) / gain_k);
   end

   always @(posedge clock) begin
      point_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) points_due.push_back(convert_point(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.rho = rsp_tdata[23:0];
            got.theta = rsp_tdata[47:24];
            got.phi = rsp_tdata[71:48];
            got.x = rsp_tdata[96:72];
            got.y = rsp_tdata[121:97];
            got.z = rsp_tdata[146:122];
            got.degen = rsp_tuser;
            if (points_due.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = points_due.pop_front();
               if (got.rho !== want.rho) begin
                  $error("out_rho exp %0d got %0d", want.rho, got.rho); fail_count++;
               end
               if (got.theta !== want.theta) begin
                  $error("out_theta exp %h got %h", want.theta, got.theta); fail_count++;
               end
               if (got.phi !== want.phi) begin
                  $error("out_phi exp %h got %h", want.phi, got.phi); fail_count++;
               end
               if (got.x !== want.x) begin
                  $error("out_x exp %h got %h", want.x, got.x); fail_count++;
               end
               if (got.y !== want.y) begin
                  $error("out_y exp %h got %h", want.y, got.y); fail_count++;
               end
               if (got.z !== want.z) begin
                  $error("out_z exp %h got %h", want.z, got.z); fail_count++;
               end
               if (got.degen !== want.degen) begin
                  $error("degenerate exp %b got %b", want.degen, got.degen); fail_count++;
               end
               if (rsp_tdata[151:147] !== 5'd0) begin
                  $error("pad exp 0 got %h", rsp_tdata[151:147]); fail_count++;
               end
            end
         end
      end
      pending = points_due.size();
   end
endmodule

// File: dv/cartesian_spherical_converter_tb.sv
module cartesian_spherical_converter_tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;
   logic         rsp_tuser;
   int           fail_count;
   int           pending;
   logic         feeding = 1'b1;
   logic         rsp_took = 1'b0;
   int           rsp_wait = 0;

   localparam logic [23:0] EXTREMES [6] = '{24'h000000, 24'h000001, 24'h7FFFFF,
                                            24'h800000, 24'hFFFFFF, 24'h800001};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cartesian_spherical_converter dut (.*);

   cartesian_spherical_checker checker_i (.*);

   task automatic send_point(logic kind, logic [23:0] a, logic [23:0] b, logic [23:0] c);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      repeat (gap) @(negedge clock);
      req_tuser = kind;
      req_tdata = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      if (!kind) req_tdata[71:0] = {c, b, a};
      else req_tdata[143:72] = {c, b, a};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic logic [23:0] coord_value();
      case ($urandom_range(0, 4))
         0: return EXTREMES[$urandom_range(0, 5)];
         1: return 24'($signed($urandom_range(0, 40)) - 20);
         2: return 24'($urandom_range(0, 4095)) << $urandom_range(0, 12);
         default: return 24'($urandom());
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   // hold off for a drawn number of cycles after each response
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_took) rsp_wait = $urandom_range(0, 6);
         if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_point(1'b0, 24'd0, 24'd0, 24'd0);
      send_point(1'b0, 24'd0, 24'd0, 24'd5);
      send_point(1'b0, 24'd0, 24'd0, 24'hFFFFF0);
      send_point(1'b0, 24'hFFFF00, 24'd0, 24'd0);
      send_point(1'b0, 24'hFFFF00, 24'hFFFFFF, 24'd3);
      send_point(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_point(1'b0, 24'h800000, 24'h800000, 24'h800000);
      send_point(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000);
      send_point(1'b0, 24'd1, 24'd0, 24'd0);
      send_point(1'b0, 24'd0, 24'h800000, 24'd0);
      send_point(1'b1, 24'hFFFFFF, 24'h000000, 24'h400000);
      send_point(1'b1, 24'hFFFFFF, 24'h800000, 24'h400000);
      send_point(1'b1, 24'hFFFFFF, 24'h7FFFFF, 24'h800000);
      send_point(1'b1, 24'hFFFFFF, 24'h200000, 24'h200000);
      send_point(1'b1, 24'hFFFFFF, 24'h400000, 24'hFFFFFF);
      send_point(1'b1, 24'h000000, 24'h123456, 24'h345678);
      send_point(1'b1, 24'h000001, 24'hC00000, 24'h000000);
      send_point(1'b1, 24'h800000, 24'h600000, 24'h900000);
      for (int n = 0; n < 1300; n++) begin
         if ($urandom_range(0, 1) == 0)
            send_point(1'b0, coord_value(), coord_value(), coord_value());
         else
            send_point(1'b1, ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom()),
                       24'($urandom()), ($urandom_range(0, 5) == 0) ? 24'h800000
                                                                   : 24'($urandom()));
      end
      feeding = 1'b0;
   end

   initial begin
      wait (!feeding && pending == 0);
      repeat (120) @(posedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
